@@ hw/rtl/mset_pkg.sv @@
// Shared codes and types for the multi-slot event timer.
`default_nettype none

package mset_pkg;

   typedef logic [2:0] code_type;

   // Request types
   localparam code_type REQ_TICK   = 3'd0;
   localparam code_type REQ_SET    = 3'd1;
   localparam code_type REQ_REMOVE = 3'd2;
   localparam code_type REQ_PAUSE  = 3'd3;
   localparam code_type REQ_RESUME = 3'd4;

   // Result kinds
   localparam code_type KIND_FIRED = 3'd0;
   localparam code_type KIND_SET   = 3'd1;
   localparam code_type KIND_FULL  = 3'd2;
   localparam code_type KIND_DONE  = 3'd3;
   localparam code_type KIND_NONE  = 3'd4;

   localparam int DELTA_WIDTH    = 20;
   localparam int DURATION_WIDTH = 32;
   localparam int SLOT_WIDTH     = 4;

endpackage

`default_nettype wire

@@ hw/rtl/mset_if.sv @@
// Valid/ready channel interfaces for timer requests and results.
`default_nettype none

interface mset_req_if
   import mset_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   code_type                  req_type;
   logic [DELTA_WIDTH-1:0]    delta;
   logic [DURATION_WIDTH-1:0] duration;
   logic                      repeat_req;
   logic [SLOT_WIDTH-1:0]     slot;

   modport source (output valid, req_type, delta, duration, repeat_req, slot,
                   input ready);
   modport sink   (input valid, req_type, delta, duration, repeat_req, slot,
                   output ready);
endinterface

interface mset_rsp_if
   import mset_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   code_type              kind;
   logic [SLOT_WIDTH-1:0] slot_out;
   logic                  last;

   modport source (output valid, kind, slot_out, last, input ready);
   modport sink   (input valid, kind, slot_out, last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/multi_slot_event_timer.sv @@
// Top level of the multi-slot event timer.
//
// A table of NUM_SLOTS interval timers. Set, remove, pause, resume and
// unknown requests answer with a single result. A tick sweeps the slot
// RAM in ascending order, one slot per cycle while the sweep is not
// stalled, through its registered read; its closing result is registered
// once every slot has been handled, as the block returns to idle. A fire
// or closing result that waits on a full result register holds the tick;
// a stalled sweep re-reads the waiting slot. Period, reload flag and
// elapsed time live in the RAM, valid and pause bits in flops that reset
// clears, so no clearing pass is needed after reset. A request is taken
// only when the block is idle and the result register is free or being
// emptied.
`default_nettype none

module multi_slot_event_timer
   import mset_pkg::*;
#(
   parameter int NUM_SLOTS  = 16,
   parameter int TIME_WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   mset_req_if.sink   req_chan,
   mset_rsp_if.source rsp_chan
);
   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int TW = TIME_WIDTH;
   localparam int RW = 2 * TW + 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_TICK = 1'b1;

   logic                   state_ff, state_in;
   logic [NUM_SLOTS-1:0]   valid_ff, valid_in;
   logic [NUM_SLOTS-1:0]   paused_ff, paused_in;
   logic [IW:0]            issue_ff, issue_in;
   logic                   ev_valid_ff, ev_valid_in;
   logic [IW-1:0]          ev_idx_ff, ev_idx_in;
   logic [DELTA_WIDTH-1:0] delta_ff, delta_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   code_type              rsp_kind_ff, rsp_kind_in;
   logic [SLOT_WIDTH-1:0] rsp_slot_ff, rsp_slot_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [RW-1:0] wr_data;
   logic [IW-1:0] rd_addr;
   logic [RW-1:0] rd_data;

   logic          alloc_found;
   logic [IW-1:0] alloc_idx;

   logic          out_free;
   logic          req_accept;

   mset_ram #(
      .WIDTH (RW),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mset_alloc #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_alloc (
      .valid_bits (valid_ff),
      .found      (alloc_found),
      .idx        (alloc_idx)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.kind     = rsp_kind_ff;
   assign rsp_chan.slot_out = rsp_slot_ff;
   assign rsp_chan.last     = rsp_last_ff;

   always_comb begin
      logic          rd_reload;
      logic [TW-1:0] rd_period;
      logic [TW-1:0] rd_elapsed;
      logic [63:0]   delta_wide;
      logic          delta_hi;
      logic [TW:0]   sum;
      logic [TW-1:0] sum_sat;
      logic          ev_active;
      logic          fire;
      logic          stall;
      logic [63:0]   dur_wide;
      logic          slot_ok;
      logic [IW-1:0] slot_idx;

      state_in     = state_ff;
      valid_in     = valid_ff;
      paused_in    = paused_ff;
      issue_in     = issue_ff;
      ev_valid_in  = ev_valid_ff;
      ev_idx_in    = ev_idx_ff;
      delta_in     = delta_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = ev_idx_ff;
      wr_data      = rd_data;
      rd_addr      = '0;

      {rd_reload, rd_period, rd_elapsed} = rd_data;

      // saturating add; a delta wider than the time word saturates at once
      delta_wide = {{(64 - DELTA_WIDTH){1'b0}}, delta_ff};
      delta_hi   = (delta_wide >> TW) != 64'd0;
      sum        = {1'b0, rd_elapsed} + {1'b0, delta_wide[TW-1:0]};
      sum_sat    = (sum[TW] || delta_hi) ? {TW{1'b1}} : sum[TW-1:0];

      ev_active = ev_valid_ff && valid_ff[ev_idx_ff] && !paused_ff[ev_idx_ff];
      fire      = sum_sat >= rd_period;
      stall     = ev_active && fire && !out_free;

      dur_wide = {{(64 - DURATION_WIDTH){1'b0}}, req_chan.duration};
      slot_ok  = 9'(req_chan.slot) < 9'(NUM_SLOTS);
      slot_idx = IW'(req_chan.slot);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_kind_in  = KIND_DONE;
               rsp_slot_in  = '0;
               priority if (req_chan.req_type == REQ_TICK) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_TICK;
                  issue_in     = '0;
                  ev_valid_in  = 1'b0;
                  delta_in     = req_chan.delta;
               end else if (req_chan.req_type == REQ_SET) begin
                  if (alloc_found) begin
                     wr_en                = 1'b1;
                     wr_addr              = alloc_idx;
                     wr_data              = {req_chan.repeat_req, dur_wide[TW-1:0],
                                             {TW{1'b0}}};
                     valid_in[alloc_idx]  = 1'b1;
                     paused_in[alloc_idx] = 1'b0;
                     rsp_kind_in          = KIND_SET;
                     rsp_slot_in          = SLOT_WIDTH'(alloc_idx);
                  end else begin
                     rsp_kind_in = KIND_FULL;
                  end
               end else if (req_chan.req_type == REQ_REMOVE ||
                            req_chan.req_type == REQ_PAUSE ||
                            req_chan.req_type == REQ_RESUME) begin
                  rsp_slot_in = req_chan.slot;
                  if (!(slot_ok && valid_ff[slot_idx])) begin
                     rsp_kind_in = KIND_NONE;
                  end else begin
                     unique case (req_chan.req_type)
                        REQ_REMOVE: begin
                           valid_in[slot_idx]  = 1'b0;
                           paused_in[slot_idx] = 1'b0;
                        end
                        REQ_PAUSE:  paused_in[slot_idx] = 1'b1;
                        default:    paused_in[slot_idx] = 1'b0;
                     endcase
                  end
               end else begin
                  // unknown request types only answer done
                  rsp_kind_in = KIND_DONE;
               end
            end
         end

         ST_TICK: begin
            if (stall) begin
               // re-read the waiting slot so its data is present next cycle
               rd_addr = ev_idx_ff;
            end else begin
               if (issue_ff < (IW + 1)'(NUM_SLOTS)) begin
                  rd_addr     = issue_ff[IW-1:0];
                  ev_valid_in = 1'b1;
                  ev_idx_in   = issue_ff[IW-1:0];
                  issue_in    = issue_ff + (IW + 1)'(1);
               end else begin
                  ev_valid_in = 1'b0;
               end

               if (ev_active) begin
                  wr_en   = 1'b1;
                  wr_addr = ev_idx_ff;
                  wr_data = {rd_reload, rd_period, fire ? {TW{1'b0}} : sum_sat};
                  if (fire) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_FIRED;
                     rsp_slot_in  = SLOT_WIDTH'(ev_idx_ff);
                     rsp_last_in  = 1'b0;
                     if (!rd_reload) begin
                        valid_in[ev_idx_ff]  = 1'b0;
                        paused_in[ev_idx_ff] = 1'b0;
                     end
                  end
               end
            end

            if (!ev_valid_ff && issue_ff == (IW + 1)'(NUM_SLOTS) && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DONE;
               rsp_slot_in  = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         paused_ff    <= '0;
         issue_ff     <= '0;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         paused_ff    <= paused_in;
         issue_ff     <= issue_in;
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ev_idx_ff   <= ev_idx_in;
      delta_ff    <= delta_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/mset_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mset_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/mset_alloc.sv @@
// Lowest free slot finder over the valid bits.
`default_nettype none

module mset_alloc #(
   parameter int NUM_SLOTS = 16,
   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  wire logic [NUM_SLOTS-1:0] valid_bits,
   output      logic                 found,
   output      logic [IW-1:0]        idx
);
   always_comb begin
      found = 1'b0;
      idx   = '0;
      // walk downwards so the lowest free slot wins
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!valid_bits[i]) begin
            found = 1'b1;
            idx   = IW'(i);
         end
      end
   end

endmodule

`default_nettype wire
